// File: design/wav_riff_pcm_header_parser_defines.svh
// Assertion macros used by the parse state machine of the WAV header parser.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef WAV_RIFF_PCM_HEADER_PARSER_DEFINES_SVH
`define WAV_RIFF_PCM_HEADER_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define WRPP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define WRPP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/wrpp_pkg.sv
// Types and constants for the WAV RIFF/PCM header parser.
// No dependencies; used by every module of the block and by the testbench.
package wrpp_pkg;

  // Parse phases
  typedef enum logic [3:0] {
    PH_RIFF = 4'd0,
    PH_SIZE = 4'd1,
    PH_WAVE = 4'd2,
    PH_HDR  = 4'd3,
    PH_SKIP = 4'd4,
    PH_FMT  = 4'd5,
    PH_DATA = 4'd6,
    PH_PAD  = 4'd7,
    PH_DONE = 4'd8
  } phase_t;

  // Verdict error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_NOT_RIFF   = 3'd1;
  localparam logic [2:0] ERR_NOT_WAVE   = 3'd2;
  localparam logic [2:0] ERR_OVERRUN    = 3'd3;
  localparam logic [2:0] ERR_NO_DATA    = 3'd4;
  localparam logic [2:0] ERR_EMPTY_DATA = 3'd5;

  // Little-endian tags as they shift in
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_MIN_LEN  = 32'd16;
  localparam logic [15:0] FMT_PCM      = 16'd1;
  localparam logic [15:0] PCM_BITS     = 16'd16;
  localparam logic [15:0] RST_CHANNELS = 16'd1;
  localparam logic [31:0] RST_RATE     = 32'd16000;
  localparam logic [15:0] RST_BITS     = 16'd16;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       end_of_file;
  } item_t;

  // One byte handed to the parser in the cycle it is consumed
  typedef struct packed {
    logic  valid;
    item_t item;
  } step_t;

  typedef struct packed {
    logic        valid;
    logic        pcm_valid;
    logic [7:0]  pcm_byte;
    logic        verdict_valid;
    logic        parse_ok;
    logic [2:0]  error_code;
    logic [31:0] rate_hz;
    logic [15:0] channel_count;
    logic [15:0] sample_bits;
    logic [31:0] pcm_length;
  } result_t;

endpackage

// File: design/wrpp_if.sv
// Valid/ready channel interfaces for the WAV header parser.
// Stand-alone; the payload is plain logic.
interface wrpp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       end_of_file;

  modport source (output valid, output file_byte, output end_of_file, input ready);
  modport sink (input valid, input file_byte, input end_of_file, output ready);
endinterface

interface wrpp_out_if;
  logic        valid;
  logic        ready;
  logic        pcm_valid;
  logic [7:0]  pcm_byte;
  logic        verdict_valid;
  logic        parse_ok;
  logic [2:0]  error_code;
  logic [31:0] rate_hz;
  logic [15:0] channel_count;
  logic [15:0] sample_bits;
  logic [31:0] pcm_length;

  modport source (
    output valid, output pcm_valid, output pcm_byte, output verdict_valid,
    output parse_ok, output error_code, output rate_hz, output channel_count,
    output sample_bits, output pcm_length, input ready
  );
  modport sink (
    input valid, input pcm_valid, input pcm_byte, input verdict_valid,
    input parse_ok, input error_code, input rate_hz, input channel_count,
    input sample_bits, input pcm_length, output ready
  );
endinterface

// File: design/wrpp_in_stage.sv
// Input register of the WAV header parser: holds one accepted byte.
// Depends on wrpp_pkg and wrpp_in_if.
module wrpp_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  wrpp_in_if.sink         in_chan,
  input  logic            out_free,
  output wrpp_pkg::step_t step
);

  logic            hold_valid_r;
  logic            hold_valid_nxt;
  wrpp_pkg::item_t item_r;
  logic            advance;

  // Byte moves on when the result side can take whatever it produces
  assign advance       = hold_valid_r && out_free;
  assign in_chan.ready = !hold_valid_r || advance;

  assign step.valid = advance;
  assign step.item  = item_r;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (in_chan.valid && in_chan.ready) begin
      hold_valid_nxt = 1'b1;
    end else if (advance) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  // Payload capture on each transaction
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      item_r.file_byte   <= in_chan.file_byte;
      item_r.end_of_file <= in_chan.end_of_file;
    end
  end

endmodule

// File: design/wrpp_parser.sv
// Parse state machine of the WAV header parser: one byte per step.
// Depends on wrpp_pkg and wav_riff_pcm_header_parser_defines.svh.
`include "wav_riff_pcm_header_parser_defines.svh"

module wrpp_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  wrpp_pkg::step_t   step,
  output wrpp_pkg::result_t res
);

  wrpp_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]       pos_r, pos_nxt;
  logic [31:0]      tag_r, tag_nxt;
  logic [31:0]      len_r, len_nxt;
  logic [31:0]      rem_r, rem_nxt;
  logic [15:0]      ftag_r, ftag_nxt;
  logic [15:0]      chan_r, chan_nxt;
  logic [31:0]      rate_r, rate_nxt;
  logic [15:0]      bits_r, bits_nxt;
  logic             fseen_r, fseen_nxt;
  logic             pad_r, pad_nxt;

  logic [7:0]  b;
  logic        eof;
  logic [31:0] tag_shift;
  logic [31:0] len_shift;
  logic [31:0] rem_dec;
  logic        rem_dec_zero;
  logic        clear;
  logic        in_body;
  logic [2:0]  end_code;

  assign b            = step.item.file_byte;
  assign eof          = step.item.end_of_file;
  assign tag_shift    = {b, tag_r[31:8]};
  assign len_shift    = {b, len_r[31:8]};
  assign rem_dec      = (rem_r != 32'd0) ? rem_r - 32'd1 : rem_r;
  assign rem_dec_zero = (rem_dec == 32'd0);
  assign clear        = !rst_n || (step.valid && eof);

  // Next state
  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    tag_nxt   = tag_r;
    len_nxt   = len_r;
    rem_nxt   = rem_r;
    ftag_nxt  = ftag_r;
    chan_nxt  = chan_r;
    rate_nxt  = rate_r;
    bits_nxt  = bits_r;
    fseen_nxt = fseen_r;
    pad_nxt   = pad_r;
    unique case (phase_r)
      wrpp_pkg::PH_RIFF, wrpp_pkg::PH_SIZE, wrpp_pkg::PH_WAVE: begin
        tag_nxt = tag_shift;
        pos_nxt = pos_r + 4'd1;
        if (pos_r == 4'd3) begin
          pos_nxt = 4'd0;
          if (phase_r == wrpp_pkg::PH_RIFF && tag_shift != wrpp_pkg::TAG_RIFF) begin
            phase_nxt = wrpp_pkg::PH_DONE;
          end else if (phase_r == wrpp_pkg::PH_WAVE &&
                       tag_shift != wrpp_pkg::TAG_WAVE) begin
            phase_nxt = wrpp_pkg::PH_DONE;
          end else if (phase_r == wrpp_pkg::PH_RIFF) begin
            phase_nxt = wrpp_pkg::PH_SIZE;
          end else if (phase_r == wrpp_pkg::PH_SIZE) begin
            phase_nxt = wrpp_pkg::PH_WAVE;
          end else begin
            phase_nxt = wrpp_pkg::PH_HDR;
          end
        end
      end
      wrpp_pkg::PH_HDR: begin
        if (pos_r < 4'd4) begin
          tag_nxt = tag_shift;
        end else begin
          len_nxt = len_shift;
        end
        pos_nxt = pos_r + 4'd1;
        if (pos_r == 4'd7) begin
          pos_nxt = 4'd0;
          pad_nxt = len_shift[0];
          rem_nxt = len_shift;
          if (tag_r == wrpp_pkg::TAG_FMT && len_shift >= wrpp_pkg::FMT_MIN_LEN) begin
            phase_nxt = wrpp_pkg::PH_FMT;
          end else if (tag_r == wrpp_pkg::TAG_DATA && fseen_r) begin
            phase_nxt = (len_shift == 32'd0) ? wrpp_pkg::PH_DONE : wrpp_pkg::PH_DATA;
          end else if (len_shift == 32'd0) begin
            phase_nxt = wrpp_pkg::PH_HDR;
          end else begin
            phase_nxt = wrpp_pkg::PH_SKIP;
          end
        end
      end
      wrpp_pkg::PH_FMT: begin
        case (pos_r)
          4'd0:    ftag_nxt = {8'h00, b};
          4'd1:    ftag_nxt = ftag_r | {b, 8'h00};
          4'd2:    chan_nxt = {8'h00, b};
          4'd3:    chan_nxt = chan_r | {b, 8'h00};
          4'd4:    rate_nxt = {24'h000000, b};
          4'd5:    rate_nxt = rate_r | {16'h0000, b, 8'h00};
          4'd6:    rate_nxt = rate_r | {8'h00, b, 16'h0000};
          4'd7:    rate_nxt = rate_r | {b, 24'h000000};
          4'd14:   bits_nxt = {8'h00, b};
          4'd15:   bits_nxt = bits_r | {b, 8'h00};
          default: ;
        endcase
        pos_nxt = pos_r + 4'd1;
        rem_nxt = rem_dec;
        if (pos_r == 4'd15) begin
          fseen_nxt = (ftag_r == wrpp_pkg::FMT_PCM) && (chan_r != 16'd0) &&
                      (bits_nxt == wrpp_pkg::PCM_BITS);
          phase_nxt = wrpp_pkg::PH_SKIP;
        end
        if (rem_dec_zero) begin
          phase_nxt = pad_r ? wrpp_pkg::PH_PAD : wrpp_pkg::PH_HDR;
          pos_nxt   = 4'd0;
        end
      end
      wrpp_pkg::PH_SKIP: begin
        rem_nxt = rem_dec;
        if (rem_dec_zero) begin
          phase_nxt = pad_r ? wrpp_pkg::PH_PAD : wrpp_pkg::PH_HDR;
          pos_nxt   = 4'd0;
        end
      end
      wrpp_pkg::PH_DATA: begin
        rem_nxt = rem_dec;
        if (rem_dec_zero) begin
          phase_nxt = wrpp_pkg::PH_DONE;
        end
      end
      wrpp_pkg::PH_PAD: begin
        phase_nxt = wrpp_pkg::PH_HDR;
        pos_nxt   = 4'd0;
      end
      wrpp_pkg::PH_DONE: ;
      default: ;
    endcase
  end

  // Early end: still owing body bytes is an overrun, anything else no data
  assign in_body  = (phase_nxt == wrpp_pkg::PH_SKIP || phase_nxt == wrpp_pkg::PH_FMT ||
                     phase_nxt == wrpp_pkg::PH_DATA) && (rem_nxt != 32'd0);
  assign end_code = in_body ? wrpp_pkg::ERR_OVERRUN : wrpp_pkg::ERR_NO_DATA;

  // Result for this step
  always_comb begin
    res               = '0;
    res.rate_hz       = rate_nxt;
    res.channel_count = chan_nxt;
    res.sample_bits   = bits_nxt;
    unique case (phase_r)
      wrpp_pkg::PH_RIFF, wrpp_pkg::PH_WAVE: begin
        if (pos_r == 4'd3 && phase_nxt == wrpp_pkg::PH_DONE) begin
          res.valid         = 1'b1;
          res.verdict_valid = 1'b1;
          res.error_code    = (phase_r == wrpp_pkg::PH_RIFF) ? wrpp_pkg::ERR_NOT_RIFF
                                                             : wrpp_pkg::ERR_NOT_WAVE;
        end
      end
      wrpp_pkg::PH_HDR: begin
        if (phase_nxt == wrpp_pkg::PH_DONE) begin
          res.valid         = 1'b1;
          res.verdict_valid = 1'b1;
          res.error_code    = wrpp_pkg::ERR_EMPTY_DATA;
        end
      end
      wrpp_pkg::PH_DATA: begin
        res.valid      = 1'b1;
        res.pcm_valid  = 1'b1;
        res.pcm_byte   = b;
        res.pcm_length = len_r;
        if (rem_dec_zero) begin
          res.verdict_valid = 1'b1;
          res.parse_ok      = 1'b1;
        end
      end
      wrpp_pkg::PH_SIZE, wrpp_pkg::PH_SKIP, wrpp_pkg::PH_FMT, wrpp_pkg::PH_PAD,
      wrpp_pkg::PH_DONE: ;
      default: ;
    endcase
    // Length of a data chunk whose header just completed is the new one
    if (eof && phase_nxt != wrpp_pkg::PH_DONE) begin
      if (!res.valid) begin
        res.pcm_length = (phase_nxt == wrpp_pkg::PH_DATA) ? len_nxt : 32'd0;
      end
      res.valid         = 1'b1;
      res.verdict_valid = 1'b1;
      res.parse_ok      = 1'b0;
      res.error_code    = end_code;
    end
    res.valid = res.valid && step.valid;
  end

  // State registers; the last byte of a file restores the reset state
  always_ff @(posedge clk) begin
    if (clear) begin
      phase_r <= wrpp_pkg::PH_RIFF;
      pos_r   <= 4'd0;
      tag_r   <= 32'd0;
      len_r   <= 32'd0;
      rem_r   <= 32'd0;
      ftag_r  <= 16'd0;
      chan_r  <= wrpp_pkg::RST_CHANNELS;
      rate_r  <= wrpp_pkg::RST_RATE;
      bits_r  <= wrpp_pkg::RST_BITS;
      fseen_r <= 1'b0;
      pad_r   <= 1'b0;
    end else if (step.valid) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      tag_r   <= tag_nxt;
      len_r   <= len_nxt;
      rem_r   <= rem_nxt;
      ftag_r  <= ftag_nxt;
      chan_r  <= chan_nxt;
      rate_r  <= rate_nxt;
      bits_r  <= bits_nxt;
      fseen_r <= fseen_nxt;
      pad_r   <= pad_nxt;
    end
  end

  // Once a verdict is out, only the last byte leaves the done phase
  `WRPP_ASSERT_NEXT(a_done_sticks, phase_r == wrpp_pkg::PH_DONE && !(step.valid && eof), phase_r == wrpp_pkg::PH_DONE, "wrpp: left done phase early")
  // Bytes owed never exceed the chunk length
  `WRPP_ASSERT_NOW(a_rem_le_len, phase_r == wrpp_pkg::PH_SKIP || phase_r == wrpp_pkg::PH_FMT || phase_r == wrpp_pkg::PH_DATA, rem_r <= len_r, "wrpp: body count above chunk length")
  // Only the fmt body counts past a header's eight bytes
  `WRPP_ASSERT_NOW(a_pos_range, phase_r != wrpp_pkg::PH_FMT, pos_r < 4'd8, "wrpp: field position out of range")

endmodule

// File: design/wrpp_out_stage.sv
// Output register of the WAV header parser: holds one result transaction.
// Depends on wrpp_pkg and wrpp_out_if.
module wrpp_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  wrpp_pkg::result_t res,
  output logic              out_free,
  wrpp_out_if.source        out_chan
);

  logic              out_valid_r;
  logic              out_valid_nxt;
  wrpp_pkg::result_t res_r;

  assign out_free = !out_valid_r || out_chan.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload; only loaded when the register is free or draining
  always_ff @(posedge clk) begin
    if (res.valid) begin
      res_r <= res;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.pcm_valid     = res_r.pcm_valid;
  assign out_chan.pcm_byte      = res_r.pcm_byte;
  assign out_chan.verdict_valid = res_r.verdict_valid;
  assign out_chan.parse_ok      = res_r.parse_ok;
  assign out_chan.error_code    = res_r.error_code;
  assign out_chan.rate_hz       = res_r.rate_hz;
  assign out_chan.channel_count = res_r.channel_count;
  assign out_chan.sample_bits   = res_r.sample_bits;
  assign out_chan.pcm_length    = res_r.pcm_length;

endmodule

// File: design/wav_riff_pcm_header_parser.sv
// WAV RIFF/PCM header parser: one file byte per transaction in, results out.
// Each accepted byte sits in the input register, and the parse step loads the output
// register from it when that register is free or being drained.
// Throughput: one byte per cycle; a byte stalls only while a result waits unaccepted.
// Synchronous active-low reset returns the parser to the RIFF tag; the byte
// flagged end_of_file does the same. Depends on wrpp_pkg, wrpp_if and stages.
module wav_riff_pcm_header_parser (
  input  logic       clk,
  input  logic       rst_n,
  wrpp_in_if.sink    in_chan,
  wrpp_out_if.source out_chan
);

  wrpp_pkg::step_t   step;
  wrpp_pkg::result_t res;
  logic              out_free;

  wrpp_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_free (out_free),
    .step     (step)
  );

  wrpp_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .res   (res)
  );

  wrpp_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .res      (res),
    .out_free (out_free),
    .out_chan (out_chan)
  );

endmodule

// File: test/tb_wav_riff_pcm_header_parser.sv
// Self-checking testbench for wav_riff_pcm_header_parser: byte streams in, PCM/verdicts out.
// Depends on wrpp_pkg and the wrpp_in_if / wrpp_out_if channel interfaces.
module tb_wav_riff_pcm_header_parser;

  localparam int LIVE_TARGET = 1100;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 20;

  logic clk;
  logic rst_n;

  wrpp_in_if  in_chan ();
  wrpp_out_if out_chan ();

  wav_riff_pcm_header_parser dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // One directed row: a byte, its eof flag, and an optional hand-written verdict
  typedef struct {
    logic [7:0] b;
    logic       eof;
    bit         typed;
    logic [2:0] code;
  } stim_row_t;

  stim_row_t stim_rows[$];
  wrpp_pkg::result_t pcm_verdict_q[$];
  logic [7:0] wav_q[$];

  // Parser shadow state
  wrpp_pkg::phase_t ps_phase;
  logic [3:0]  ps_pos;
  logic [31:0] ps_tag;
  logic [31:0] ps_len;
  logic [32:0] ps_remain;
  logic [15:0] ps_fmt_tag;
  logic [15:0] ps_channels;
  logic [31:0] ps_rate;
  logic [15:0] ps_bits;
  logic        ps_fmt_ok;
  logic        ps_pad;
  logic        ps_done;

  // Driver side info read by the monitor
  bit         row_typed;
  logic [2:0] row_code;
  bit         steady;

  int fail_count;
  int live_items;
  int bytes_taken;
  int results_seen;
  int pcm_seen;
  int verdicts_seen;
  int file_no;
  int cycle_count;

  function automatic void parser_clear();
    ps_phase    = wrpp_pkg::PH_RIFF;
    ps_pos      = '0;
    ps_tag      = '0;
    ps_len      = '0;
    ps_remain   = '0;
    ps_fmt_tag  = '0;
    ps_channels = wrpp_pkg::RST_CHANNELS;
    ps_rate     = wrpp_pkg::RST_RATE;
    ps_bits     = wrpp_pkg::RST_BITS;
    ps_fmt_ok   = 1'b0;
    ps_pad      = 1'b0;
    ps_done     = 1'b0;
  endfunction

  function automatic wrpp_pkg::result_t make_result(logic pv, logic [7:0] pb, logic vv,
                                                    logic ok, logic [2:0] err,
                                                    logic [31:0] plen);
    wrpp_pkg::result_t r;
    r               = '0;
    r.valid         = 1'b1;
    r.pcm_valid     = pv;
    r.pcm_byte      = pb;
    r.verdict_valid = vv;
    r.parse_ok      = ok;
    r.error_code    = err;
    r.rate_hz       = ps_rate;
    r.channel_count = ps_channels;
    r.sample_bits   = ps_bits;
    r.pcm_length    = plen;
    return r;
  endfunction

  function automatic void close_chunk();
    ps_phase = ps_pad ? wrpp_pkg::PH_PAD : wrpp_pkg::PH_HDR;
    ps_pos   = '0;
  endfunction

  // Advance the shadow parser by one byte; r.valid marks that a result is due
  function automatic wrpp_pkg::result_t parse_wav_byte(logic [7:0] b, logic eof);
    wrpp_pkg::result_t r;
    logic [3:0] p;
    logic       in_body;
    logic [2:0] code;
    r = '0;
    case (ps_phase)
      wrpp_pkg::PH_RIFF, wrpp_pkg::PH_SIZE, wrpp_pkg::PH_WAVE: begin
        ps_tag = {b, ps_tag[31:8]};
        ps_pos = ps_pos + 4'd1;
        if (ps_pos >= 4'd4) begin
          ps_pos = '0;
          if (ps_phase == wrpp_pkg::PH_RIFF && ps_tag != wrpp_pkg::TAG_RIFF) begin
            r = make_result(1'b0, 8'h00, 1'b1, 1'b0, wrpp_pkg::ERR_NOT_RIFF, 32'd0);
            ps_done  = 1'b1;
            ps_phase = wrpp_pkg::PH_DONE;
          end else if (ps_phase == wrpp_pkg::PH_WAVE && ps_tag != wrpp_pkg::TAG_WAVE) begin
            r = make_result(1'b0, 8'h00, 1'b1, 1'b0, wrpp_pkg::ERR_NOT_WAVE, 32'd0);
            ps_done  = 1'b1;
            ps_phase = wrpp_pkg::PH_DONE;
          end else if (ps_phase == wrpp_pkg::PH_RIFF) begin
            ps_phase = wrpp_pkg::PH_SIZE;
          end else if (ps_phase == wrpp_pkg::PH_SIZE) begin
            ps_phase = wrpp_pkg::PH_WAVE;
          end else begin
            ps_phase = wrpp_pkg::PH_HDR;
          end
        end
      end
      wrpp_pkg::PH_HDR: begin
        if (ps_pos < 4'd4) ps_tag = {b, ps_tag[31:8]};
        else ps_len = {b, ps_len[31:8]};
        ps_pos = ps_pos + 4'd1;
        if (ps_pos >= 4'd8) begin
          ps_pos    = '0;
          ps_pad    = ps_len[0];
          ps_remain = {1'b0, ps_len};
          if (ps_tag == wrpp_pkg::TAG_FMT && ps_len >= wrpp_pkg::FMT_MIN_LEN) begin
            ps_phase = wrpp_pkg::PH_FMT;
          end else if (ps_tag == wrpp_pkg::TAG_DATA && ps_fmt_ok) begin
            if (ps_len == 32'd0) begin
              r = make_result(1'b0, 8'h00, 1'b1, 1'b0, wrpp_pkg::ERR_EMPTY_DATA, 32'd0);
              ps_done  = 1'b1;
              ps_phase = wrpp_pkg::PH_DONE;
            end else begin
              ps_phase = wrpp_pkg::PH_DATA;
            end
          end else if (ps_len == 32'd0) begin
            close_chunk();
          end else begin
            ps_phase = wrpp_pkg::PH_SKIP;
          end
        end
      end
      wrpp_pkg::PH_FMT: begin
        p = ps_pos;
        case (p)
          4'd0:  ps_fmt_tag  = {8'h00, b};
          4'd1:  ps_fmt_tag  = ps_fmt_tag | {b, 8'h00};
          4'd2:  ps_channels = {8'h00, b};
          4'd3:  ps_channels = ps_channels | {b, 8'h00};
          4'd4:  ps_rate     = {24'h0, b};
          4'd5:  ps_rate     = ps_rate | {16'h0, b, 8'h00};
          4'd6:  ps_rate     = ps_rate | {8'h0, b, 16'h0};
          4'd7:  ps_rate     = ps_rate | {b, 24'h0};
          4'd14: ps_bits     = {8'h00, b};
          4'd15: ps_bits     = ps_bits | {b, 8'h00};
          default: ;
        endcase
        ps_pos = p + 4'd1;
        if (ps_remain != '0) ps_remain = ps_remain - 33'd1;
        if (p == 4'd15) begin
          ps_fmt_ok = (ps_fmt_tag == wrpp_pkg::FMT_PCM) && (ps_channels != 16'd0) &&
                      (ps_bits == wrpp_pkg::PCM_BITS);
          ps_phase  = wrpp_pkg::PH_SKIP;
        end
        if (ps_remain == '0) close_chunk();
      end
      wrpp_pkg::PH_SKIP: begin
        if (ps_remain != '0) ps_remain = ps_remain - 33'd1;
        if (ps_remain == '0) close_chunk();
      end
      wrpp_pkg::PH_DATA: begin
        if (ps_remain != '0) ps_remain = ps_remain - 33'd1;
        if (ps_remain == '0) begin
          r = make_result(1'b1, b, 1'b1, 1'b1, wrpp_pkg::ERR_NONE, ps_len);
          ps_done  = 1'b1;
          ps_phase = wrpp_pkg::PH_DONE;
        end else begin
          r = make_result(1'b1, b, 1'b0, 1'b0, wrpp_pkg::ERR_NONE, ps_len);
        end
      end
      wrpp_pkg::PH_PAD: begin
        ps_phase = wrpp_pkg::PH_HDR;
        ps_pos   = '0;
      end
      default: ;
    endcase

    // Final byte: late verdict if none yet, then back to the start of a file
    if (eof) begin
      if (!ps_done) begin
        in_body = (ps_phase == wrpp_pkg::PH_SKIP || ps_phase == wrpp_pkg::PH_FMT ||
                   ps_phase == wrpp_pkg::PH_DATA) && (ps_remain != '0);
        code    = in_body ? wrpp_pkg::ERR_OVERRUN : wrpp_pkg::ERR_NO_DATA;
        if (!r.valid) begin
          r = make_result(1'b0, 8'h00, 1'b1, 1'b0, code,
                          (ps_phase == wrpp_pkg::PH_DATA) ? ps_len : 32'd0);
        end else begin
          r.verdict_valid = 1'b1;
          r.parse_ok      = 1'b0;
          r.error_code    = code;
        end
      end
      parser_clear();
    end
    return r;
  endfunction

  function automatic string fmt_result(wrpp_pkg::result_t r);
    return $sformatf("pcm=%0d/%02h verdict=%0d ok=%0d err=%0d rate=%0d ch=%0d bits=%0d len=%0d",
                     r.pcm_valid, r.pcm_byte, r.verdict_valid, r.parse_ok, r.error_code,
                     r.rate_hz, r.channel_count, r.sample_bits, r.pcm_length);
  endfunction

  function automatic void add_row(logic [7:0] b, logic eof, bit typed, logic [2:0] code);
    stim_row_t row;
    row.b     = b;
    row.eof   = eof;
    row.typed = typed;
    row.code  = code;
    stim_rows.push_back(row);
  endfunction

  // File assembly helpers (little-endian fields)
  function automatic void put_le(logic [31:0] v, int n);
    for (int i = 0; i < n; i++) wav_q.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_rand(int n);
    for (int i = 0; i < n; i++) wav_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void put_chunk(logic [31:0] tag, logic [31:0] len);
    put_le(tag, 4);
    put_le(len, 4);
    put_rand(int'(len));
    if (len[0]) put_rand(1);
  endfunction

  // Build one file into wav_q: mostly well-formed, some noise, truncation, corruption
  function automatic void build_file();
    int          kind;
    int          pick;
    int          cut;
    logic [31:0] len;
    logic [7:0]  dropped;
    bit          runaway;
    wav_q.delete();
    runaway = 1'b0;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      put_rand($urandom_range(1, 16));
    end else if (kind == 1) begin
      put_le(wrpp_pkg::TAG_RIFF, 4);
      put_rand($urandom_range(1, 20));
    end else begin
      put_le(($urandom_range(0, 19) == 0) ? $urandom : wrpp_pkg::TAG_RIFF, 4);
      put_le($urandom, 4);
      put_le(($urandom_range(0, 19) == 0) ? $urandom : wrpp_pkg::TAG_WAVE, 4);
      // chunks ahead of the format chunk
      for (int i = $urandom_range(0, 2); i > 0; i--) begin
        pick = $urandom_range(0, 2);
        if (pick == 0) put_chunk($urandom, $urandom_range(0, 5));
        else if (pick == 1) put_chunk(wrpp_pkg::TAG_FMT, $urandom_range(0, 15));
        else put_chunk(wrpp_pkg::TAG_DATA, $urandom_range(0, 4));
      end
      // format chunk
      len = 32'd16 + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
      put_le(wrpp_pkg::TAG_FMT, 4);
      put_le(len, 4);
      put_le(($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : wrpp_pkg::FMT_PCM, 2);
      pick = $urandom_range(0, 9);
      put_le((pick == 0) ? 0 : (pick == 1) ? $urandom_range(0, 65535) : $urandom_range(1, 2), 2);
      put_le(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(8000, 48000), 4);
      put_rand(6);
      put_le(($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : wrpp_pkg::PCM_BITS, 2);
      put_rand(int'(len) - 16);
      if (len[0]) put_rand(1);
      if ($urandom_range(0, 2) == 0) put_chunk($urandom, $urandom_range(0, 5));
      // data chunk: empty, runaway length, or a few bytes
      pick = $urandom_range(0, 11);
      if (pick == 0) begin
        put_chunk(wrpp_pkg::TAG_DATA, 32'd0);
      end else if (pick == 1) begin
        len = $urandom_range(0, 1) ? 32'hFFFF_FFFF : ($urandom | 32'h0000_0100);
        put_le(wrpp_pkg::TAG_DATA, 4);
        put_le(len, 4);
        put_rand($urandom_range(0, 8));
        runaway = 1'b1;
      end else begin
        put_chunk(wrpp_pkg::TAG_DATA, $urandom_range(1, 12));
      end
      if (!runaway) put_rand($urandom_range(0, 3));
      if ($urandom_range(0, 4) == 0) begin
        cut = $urandom_range(1, wav_q.size());
        while (wav_q.size() > cut) dropped = wav_q.pop_back();
      end
      if ($urandom_range(0, 9) == 0)
        wav_q[$urandom_range(0, wav_q.size() - 1)] = 8'($urandom_range(0, 255));
    end
  endfunction

  // Present one byte; returns at the falling edge after its transaction
  task automatic send_byte(logic [7:0] b, logic eof, bit typed, logic [2:0] code);
    while (!steady && $urandom_range(0, 99) < 18) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.file_byte   <= b;
    in_chan.end_of_file <= eof;
    row_typed = typed;
    row_code  = code;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop sending until every outstanding result has come back
  task automatic hold_until_drained();
    in_chan.valid <= 1'b0;
    @(negedge clk);
    while (pcm_verdict_q.size() != 0) @(negedge clk);
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             pcm_verdict_q.size());
    $display("wav_riff_pcm_header_parser test failed");
    $finish;
  end

  // Result side backpressure
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_chan.ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 18);
    end
  end

  // Monitor: check results against the oldest expectation, then predict new input
  always @(posedge clk) begin
    wrpp_pkg::result_t seen;
    wrpp_pkg::result_t want;
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) begin
        seen               = '0;
        seen.valid         = 1'b1;
        seen.pcm_valid     = out_chan.pcm_valid;
        seen.pcm_byte      = out_chan.pcm_byte;
        seen.verdict_valid = out_chan.verdict_valid;
        seen.parse_ok      = out_chan.parse_ok;
        seen.error_code    = out_chan.error_code;
        seen.rate_hz       = out_chan.rate_hz;
        seen.channel_count = out_chan.channel_count;
        seen.sample_bits   = out_chan.sample_bits;
        seen.pcm_length    = out_chan.pcm_length;
        results_seen++;
        if (pcm_verdict_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result at cycle %0d: %s", cycle_count, fmt_result(seen));
        end else begin
          want = pcm_verdict_q.pop_front();
          if (seen.pcm_valid !== want.pcm_valid || seen.pcm_byte !== want.pcm_byte ||
              seen.verdict_valid !== want.verdict_valid ||
              seen.parse_ok !== want.parse_ok || seen.error_code !== want.error_code ||
              seen.rate_hz !== want.rate_hz ||
              seen.channel_count !== want.channel_count ||
              seen.sample_bits !== want.sample_bits ||
              seen.pcm_length !== want.pcm_length) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch at cycle %0d", cycle_count);
              $display("  expected %s", fmt_result(want));
              $display("  actual   %s", fmt_result(seen));
            end
          end
          if (want.pcm_valid) pcm_seen++;
          if (want.verdict_valid) verdicts_seen++;
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        if (ps_phase != wrpp_pkg::PH_DONE) live_items++;
        bytes_taken++;
        want = parse_wav_byte(in_chan.file_byte, in_chan.end_of_file);
        if (row_typed) begin
          want               = '0;
          want.valid         = 1'b1;
          want.verdict_valid = 1'b1;
          want.error_code    = row_code;
          want.rate_hz       = wrpp_pkg::RST_RATE;
          want.channel_count = wrpp_pkg::RST_CHANNELS;
          want.sample_bits   = wrpp_pkg::RST_BITS;
        end
        if (want.valid) pcm_verdict_q.push_back(want);
      end
    end
  end

  // Stimulus
  initial begin
    rst_n               = 1'b0;
    in_chan.valid       = 1'b0;
    in_chan.file_byte   = 8'h00;
    in_chan.end_of_file = 1'b0;
    row_typed           = 1'b0;
    row_code            = wrpp_pkg::ERR_NONE;
    steady              = 1'b0;
    fail_count          = 0;
    live_items          = 0;
    bytes_taken         = 0;
    results_seen        = 0;
    pcm_seen            = 0;
    verdicts_seen       = 0;
    file_no             = 0;
    parser_clear();

    // Bad RIFF tag, then ignored bytes up to the final byte
    add_row(8'h52, 1'b0, 1'b0, wrpp_pkg::ERR_NONE);
    add_row(8'h49, 1'b0, 1'b0, wrpp_pkg::ERR_NONE);
    add_row(8'h46, 1'b0, 1'b0, wrpp_pkg::ERR_NONE);
    add_row(8'h58, 1'b0, 1'b1, wrpp_pkg::ERR_NOT_RIFF);
    add_row(8'hFF, 1'b0, 1'b0, wrpp_pkg::ERR_NONE);
    add_row(8'h00, 1'b1, 1'b0, wrpp_pkg::ERR_NONE);
    // File ends inside the preamble
    add_row(8'h52, 1'b0, 1'b0, wrpp_pkg::ERR_NONE);
    add_row(8'h49, 1'b1, 1'b1, wrpp_pkg::ERR_NO_DATA);
    // Good RIFF, extreme size bytes, bad WAVE tag
    add_row(8'h52, 1'b0, 1'b0, wrpp_pkg::ERR_NONE);
    add_row(8'h49, 1'b0, 1'b0, wrpp_pkg::ERR_NONE);
    add_row(8'h46, 1'b0, 1'b0, wrpp_pkg::ERR_NONE);
    add_row(8'h46, 1'b0, 1'b0, wrpp_pkg::ERR_NONE);
    add_row(8'hFF, 1'b0, 1'b0, wrpp_pkg::ERR_NONE);
    add_row(8'h00, 1'b0, 1'b0, wrpp_pkg::ERR_NONE);
    add_row(8'hFF, 1'b0, 1'b0, wrpp_pkg::ERR_NONE);
    add_row(8'h00, 1'b0, 1'b0, wrpp_pkg::ERR_NONE);
    add_row(8'h57, 1'b0, 1'b0, wrpp_pkg::ERR_NONE);
    add_row(8'h41, 1'b0, 1'b0, wrpp_pkg::ERR_NONE);
    add_row(8'h56, 1'b0, 1'b0, wrpp_pkg::ERR_NONE);
    add_row(8'h58, 1'b0, 1'b1, wrpp_pkg::ERR_NOT_WAVE);
    add_row(8'hA5, 1'b1, 1'b0, wrpp_pkg::ERR_NONE);
    // One-byte file
    add_row(8'hFF, 1'b1, 1'b1, wrpp_pkg::ERR_NO_DATA);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (stim_rows[i])
      send_byte(stim_rows[i].b, stim_rows[i].eof, stim_rows[i].typed, stim_rows[i].code);
    hold_until_drained();

    // Random files until enough bytes have been accepted
    while (bytes_taken < LIVE_TARGET) begin
      build_file();
      steady = (file_no >= 6 && file_no < 10);
      foreach (wav_q[j])
        send_byte(wav_q[j], (j == wav_q.size() - 1), 1'b0, wrpp_pkg::ERR_NONE);
      file_no++;
      if (file_no % 7 == 3) hold_until_drained();
    end
    steady = 1'b0;
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (pcm_verdict_q.size() != 0) begin
      fail_count += pcm_verdict_q.size();
      $display("%0d expected results never arrived", pcm_verdict_q.size());
    end
    $display("covered %0d directed bytes and %0d random files, %0d bytes accepted (%0d parsed)",
             stim_rows.size(), file_no, bytes_taken, live_items);
    $display("checked %0d results: %0d PCM bytes, %0d verdicts, %0d failures",
             results_seen, pcm_seen, verdicts_seen, fail_count);
    if (fail_count == 0) begin
      $display("wav_riff_pcm_header_parser test passed");
    end else begin
      $display("wav_riff_pcm_header_parser test failed");
    end
    $finish;
  end

endmodule
